>>> src/sacrs_pkg.sv
// ----------------------------------------------------------------------------
// sacrs_pkg
// Shared constants, register map, command codes and channel value table for
// the SPI ADC command register slave.
// ----------------------------------------------------------------------------
package sacrs_pkg;

    // Field and counter widths
    localparam int BYTE_W = 8;
    localparam int IDX_W  = 6;   // register pointer, holds 0..32
    localparam int CNT_W  = 6;   // read/write counts, hold 0..32
    localparam int PTR_W  = 5;   // pointer field carried in a command byte
    localparam int CH_W   = 16;
    localparam int NUM_CH = 16;
    localparam int SEL_W  = 4;

    // Register map
    localparam logic [PTR_W-1:0] ADDR_ID       = 5'd0;
    localparam logic [PTR_W-1:0] ADDR_STATUS   = 5'd1;
    localparam logic [PTR_W-1:0] ADDR_INPMUX   = 5'd2;
    localparam logic [PTR_W-1:0] ADDR_DATARATE = 5'd4;
    localparam logic [PTR_W-1:0] ADDR_REF      = 5'd5;
    localparam logic [PTR_W-1:0] ADDR_IDAC_MUX = 5'd7;
    localparam logic [PTR_W-1:0] ADDR_SYS      = 5'd9;
    localparam logic [PTR_W-1:0] ADDR_FSCAL1   = 5'd15;

    // Command codes
    localparam logic [BYTE_W-1:0] CMD_NOP        = 8'h00;
    localparam logic [BYTE_W-1:0] CMD_RDATA      = 8'h12;
    localparam logic [BYTE_W-1:0] CMD_RDATA_MASK = 8'hfe;
    localparam logic [BYTE_W-1:0] CMD_RREG       = 8'h20;
    localparam logic [BYTE_W-1:0] CMD_WREG       = 8'h40;
    localparam logic [BYTE_W-1:0] CMD_TOP_MASK   = 8'he0;

    // STATUS busy flag position
    localparam int STATUS_BUSY_BIT = 5;

    // Configuration register map (word index)
    localparam logic CFG_STARTUP_DELAY = 1'b0;

    localparam logic [CH_W-1:0] CHANNEL_SEED = 16'h96a9;

    typedef logic [NUM_CH-1:0][CH_W-1:0] chan_tbl_t;

    // Power-up value of each register
    function automatic logic [BYTE_W-1:0] reg_default(input logic [PTR_W-1:0] addr);
        logic [BYTE_W-1:0] v;
        case (addr)
            ADDR_ID:       v = 8'h04;
            ADDR_STATUS:   v = 8'h80;
            ADDR_INPMUX:   v = 8'h01;
            ADDR_DATARATE: v = 8'h14;
            ADDR_REF:      v = 8'h10;
            ADDR_IDAC_MUX: v = 8'hff;
            ADDR_SYS:      v = 8'h10;
            ADDR_FSCAL1:   v = 8'h40;
            default:       v = 8'h00;
        endcase
        return v;
    endfunction

    // Fake channel values: rotate left by one, then add seven
    function automatic chan_tbl_t chan_table();
        chan_tbl_t t;
        logic [CH_W-1:0] x;
        x = CHANNEL_SEED;
        for (int i = 0; i < NUM_CH; i++)
        begin
            x = {x[CH_W-2:0], x[CH_W-1]};
            x = x + 16'd7;
            t[i] = x;
        end
        return t;
    endfunction

    localparam chan_tbl_t CHAN_TBL = chan_table();

endpackage

>>> src/spi_adc_command_register_slave_unit.sv
// ----------------------------------------------------------------------------
// spi_adc_command_register_slave_unit
// Slave side of an ADC SPI command set: one full-duplex byte per transfer.
// Each incoming byte yields one outgoing byte taken from the state before it.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload                    Transfer when
//  s_*       in         tdata[7:0] = mosi_byte     s_tvalid & s_tready
//  m_*       out        tdata[7:0] = miso_byte     m_tvalid & m_tready
//  APB       in/out     startup_delay_enable @0x0  psel & penable & pwrite
//
//  One byte per clock sustained while m_tready allows; an input transfer
//  reaches output valid via the register memory read, then output register.
//  The register file sits in a memory with a registered read port;
//  STATUS and INPMUX are kept in flops for the busy flag and channel select.
//  Reset restores power-up register values at once through per-entry valid
//  bits; no clearing pass is needed.
//  A stalled output holds the middle stage, and input is refused only when
//  both stages are full.
// ----------------------------------------------------------------------------
module spi_adc_command_register_slave_unit #(
    parameter int NUM_REGS           = 18,
    parameter int OUT_DEPTH          = 4,
    parameter int STATUS_DELAY_READS = 3
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sacrs_pkg::BYTE_W-1:0]  s_tdata,   // [7:0] mosi_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sacrs_pkg::BYTE_W-1:0]  m_tdata,   // [7:0] miso_byte
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import sacrs_pkg::*;

    localparam int  RA_W       = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int  QA_W       = $clog2(OUT_DEPTH);
    localparam int  QC_W       = $clog2(OUT_DEPTH + 1);
    localparam logic HAS_STATUS = (NUM_REGS > int'(ADDR_STATUS));
    localparam logic HAS_INPMUX = (NUM_REGS > int'(ADDR_INPMUX));
    localparam logic [IDX_W-1:0] NREG_IDX = IDX_W'(NUM_REGS);
    localparam logic [IDX_W-1:0] IDX_STATUS = IDX_W'(ADDR_STATUS);
    localparam logic [IDX_W-1:0] IDX_INPMUX = IDX_W'(ADDR_INPMUX);

    // Control state
    logic                 sde_reg;
    logic [IDX_W-1:0]     idx_reg,      idx_next;
    logic [CNT_W-1:0]     rd_cnt_reg,   rd_cnt_next;
    logic [CNT_W-1:0]     wr_cnt_reg,   wr_cnt_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic                 pend_wr_reg,  pend_wr_next;
    logic [QC_W-1:0]      qcnt_reg,     qcnt_next;
    logic [1:0]           srl_reg,      srl_next;
    logic [BYTE_W-1:0]    status_reg,   status_next;
    logic [BYTE_W-1:0]    inpmux_reg,   inpmux_next;
    logic [BYTE_W-1:0]    queue_reg [OUT_DEPTH];
    logic [BYTE_W-1:0]    queue_next [OUT_DEPTH];

    // Pipeline
    logic                 s1_valid_reg;
    logic                 s1_mem_reg;
    logic [BYTE_W-1:0]    s1_byte_reg;
    logic                 out_valid_reg;
    logic [BYTE_W-1:0]    out_byte_reg;

    logic                 s_acc;
    logic                 s1_adv;
    logic                 rd_from_mem;
    logic [BYTE_W-1:0]    rd_byte;
    logic                 mem_re;
    logic                 mem_we;
    logic [IDX_W-1:0]     idx_v;
    logic [QC_W-1:0]      cnt_v;
    logic [BYTE_W-1:0]    st_v;
    logic [CH_W-1:0]      chv;
    logic [SEL_W-1:0]     chan_sel;
    logic [BYTE_W-1:0]    d;
    logic [BYTE_W-1:0]    mem_rdata;
    logic                 cfg_wr;

    assign d      = s_tdata;
    assign s1_adv = !out_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || s1_adv;
    assign s_acc  = s_tvalid && s_tready;
    assign chan_sel = HAS_INPMUX ? inpmux_reg[BYTE_W-1:BYTE_W-SEL_W] : '0;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == CFG_STARTUP_DELAY) ? {31'b0, sde_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sde_reg <= 1'b0;
        end
        else if (cfg_wr && paddr[2] == CFG_STARTUP_DELAY)
        begin
            sde_reg <= pwdata[0];
        end
    end

    // Decode one byte: produce the outgoing byte, then act on the incoming one
    always_comb
    begin
        idx_next        = idx_reg;
        rd_cnt_next     = rd_cnt_reg;
        wr_cnt_next     = wr_cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_wr_next    = pend_wr_reg;
        srl_next        = srl_reg;
        status_next     = status_reg;
        inpmux_next     = inpmux_reg;
        queue_next      = queue_reg;
        rd_from_mem     = 1'b0;
        rd_byte         = '0;
        mem_re          = 1'b0;
        mem_we          = 1'b0;
        idx_v           = idx_reg;
        cnt_v           = qcnt_reg;
        st_v            = status_reg;
        chv             = CHAN_TBL[chan_sel];
        if (s_acc)
        begin
            // Outgoing byte: queue first, then register read
            if (qcnt_reg != '0)
            begin
                cnt_v   = qcnt_reg - 1'b1;
                rd_byte = queue_reg[cnt_v[QA_W-1:0]];
            end
            else if (rd_cnt_reg != '0)
            begin
                rd_cnt_next = rd_cnt_reg - 1'b1;
                if (idx_reg < NREG_IDX)
                begin
                    if (HAS_STATUS && idx_reg == IDX_STATUS)
                    begin
                        if (sde_reg)
                        begin
                            st_v[STATUS_BUSY_BIT] = (srl_reg != 2'd0);
                            if (srl_reg != 2'd0)
                            begin
                                srl_next = srl_reg - 2'd1;
                            end
                        end
                        status_next = st_v;
                        rd_byte     = st_v;
                    end
                    else if (HAS_INPMUX && idx_reg == IDX_INPMUX)
                    begin
                        rd_byte = inpmux_reg;
                    end
                    else
                    begin
                        rd_from_mem = 1'b1;
                        mem_re      = 1'b1;
                    end
                    idx_v = idx_reg + 1'b1;
                end
            end
            idx_next = idx_v;

            // Incoming byte
            if (wr_cnt_reg != '0)
            begin
                wr_cnt_next = wr_cnt_reg - 1'b1;
                if (idx_v < NREG_IDX)
                begin
                    mem_we = 1'b1;
                    if (HAS_STATUS && idx_v == IDX_STATUS)
                    begin
                        status_next = d;
                    end
                    if (HAS_INPMUX && idx_v == IDX_INPMUX)
                    begin
                        inpmux_next = d;
                    end
                    idx_next = idx_v + 1'b1;
                end
            end
            else if (pend_valid_reg)
            begin
                if (pend_wr_reg)
                begin
                    wr_cnt_next = {1'b0, d[PTR_W-1:0]} + 1'b1;
                end
                else
                begin
                    rd_cnt_next = {1'b0, d[PTR_W-1:0]} + 1'b1;
                end
                pend_valid_next = 1'b0;
            end
            else if ((d & CMD_RDATA_MASK) == CMD_RDATA)
            begin
                // Push LSB, then MSB; drop what does not fit
                if (cnt_v < QC_W'(OUT_DEPTH))
                begin
                    queue_next[cnt_v[QA_W-1:0]] = chv[BYTE_W-1:0];
                    cnt_v = cnt_v + 1'b1;
                end
                if (cnt_v < QC_W'(OUT_DEPTH))
                begin
                    queue_next[cnt_v[QA_W-1:0]] = chv[CH_W-1:BYTE_W];
                    cnt_v = cnt_v + 1'b1;
                end
            end
            else if (d != CMD_NOP)
            begin
                if ((d & CMD_TOP_MASK) == CMD_RREG || (d & CMD_TOP_MASK) == CMD_WREG)
                begin
                    idx_next        = {1'b0, d[PTR_W-1:0]};
                    pend_valid_next = 1'b1;
                    pend_wr_next    = ((d & CMD_TOP_MASK) == CMD_WREG);
                end
            end
        end
        qcnt_next = cnt_v;
    end

    // Control state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            rd_cnt_reg     <= '0;
            wr_cnt_reg     <= '0;
            pend_valid_reg <= 1'b0;
            pend_wr_reg    <= 1'b0;
            qcnt_reg       <= '0;
            srl_reg        <= 2'(STATUS_DELAY_READS);
            status_reg     <= reg_default(ADDR_STATUS);
            inpmux_reg     <= reg_default(ADDR_INPMUX);
        end
        else
        begin
            idx_reg        <= idx_next;
            rd_cnt_reg     <= rd_cnt_next;
            wr_cnt_reg     <= wr_cnt_next;
            pend_valid_reg <= pend_valid_next;
            pend_wr_reg    <= pend_wr_next;
            qcnt_reg       <= qcnt_next;
            srl_reg        <= srl_next;
            status_reg     <= status_next;
            inpmux_reg     <= inpmux_next;
        end
    end

    // Queue payload
    always_ff @(posedge clk)
    begin
        queue_reg <= queue_next;
    end

    // Register file memory
    sacrs_regmem #(
        .NUM_REGS (NUM_REGS)
    ) u_regmem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mem_we),
        .wr_addr (idx_v[RA_W-1:0]),
        .wr_data (d),
        .rd_en   (mem_re),
        .rd_addr (idx_reg[RA_W-1:0]),
        .rd_data (mem_rdata)
    );

    // Middle stage: waits for memory data, holds while output stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_acc)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            s1_mem_reg  <= rd_from_mem;
            s1_byte_reg <= rd_byte;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_valid_reg)
        begin
            out_byte_reg <= s1_mem_reg ? mem_rdata : s1_byte_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;

    // Checks
    a_qcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        qcnt_reg <= QC_W'(OUT_DEPTH))
        else $error("output queue count beyond depth");

    a_pend_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> wr_cnt_reg == '0)
        else $error("command pending while a write burst is open");

    a_no_mem_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && qcnt_reg == '0 && rd_cnt_reg == '0 |=> !s1_mem_reg)
        else $error("memory selected without a register read");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> s1_valid_reg && out_valid_reg)
        else $error("input refused with a free stage");

endmodule

>>> src/sacrs_regmem.sv
// ----------------------------------------------------------------------------
// sacrs_regmem
// Register file memory: one write port, one registered read port, with a
// valid bit per entry so unwritten entries read back their power-up value.
// ----------------------------------------------------------------------------
module sacrs_regmem #(
    parameter int NUM_REGS = 18
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    wr_en,
    input  logic [(NUM_REGS > 1 ? $clog2(NUM_REGS) : 1)-1:0] wr_addr,
    input  logic [sacrs_pkg::BYTE_W-1:0]            wr_data,
    input  logic                                    rd_en,
    input  logic [(NUM_REGS > 1 ? $clog2(NUM_REGS) : 1)-1:0] rd_addr,
    output logic [sacrs_pkg::BYTE_W-1:0]            rd_data
);
    import sacrs_pkg::*;

    logic [BYTE_W-1:0]   mem [NUM_REGS];
    logic [NUM_REGS-1:0] valid_reg;
    logic [BYTE_W-1:0]   rdata_reg;
    logic                rvalid_reg;
    logic [BYTE_W-1:0]   rdflt_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Mark written entries
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Registered read port, hold data between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg  <= mem[rd_addr];
            rvalid_reg <= valid_reg[rd_addr];
            rdflt_reg  <= reg_default(PTR_W'(rd_addr));
        end
    end

    assign rd_data = rvalid_reg ? rdata_reg : rdflt_reg;

endmodule
